@@ rtl/core/assert_macros.svh @@
// assertion macros used by the matcher rtl
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/epm_pkg.sv @@
// shared constants, action codes and control structs of the byte pattern matcher
// no dependencies
`timescale 1ns / 1ps

package epm_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int ALEN_W      = $clog2(MAX_PATTERN + 1);

    localparam int BYTE_W = 8;
    localparam int POS_W  = 32;
    localparam int ACT_W  = 2;
    localparam int PIDX_W = 6;
    localparam int CFG_W  = 7;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD  = 2'd0,
        ACT_TEXT  = 2'd1,
        ACT_START = 2'd2
    } action_t;

    typedef struct packed {
        logic              load_en;
        logic              shift_en;
        logic              clear_en;
        logic              rotate_en;
        logic [IDX_W-1:0]  offset;
        logic [PIDX_W-1:0] index;
        logic [BYTE_W-1:0] data;
    } chain_ctl_t;

    typedef struct packed {
        logic              load_en;
        logic              shift_en;
        logic              clear_en;
        logic              rotate_en;
        logic [BYTE_W-1:0] data;
    } cell_ctl_t;

endpackage

@@ rtl/core/epm_item_if.sv @@
// input item channel of the byte pattern matcher
// depends on epm_pkg
`timescale 1ns / 1ps

interface epm_item_if;
    logic                       valid;
    logic                       ready;
    logic [epm_pkg::ACT_W-1:0]  action;
    logic [epm_pkg::PIDX_W-1:0] pattern_index;
    logic [epm_pkg::BYTE_W-1:0] byte_value;

    modport source (output valid, action, pattern_index, byte_value, input ready);
    modport sink (input valid, action, pattern_index, byte_value, output ready);
endinterface

@@ rtl/core/epm_result_if.sv @@
// result channel of the byte pattern matcher
// depends on epm_pkg
`timescale 1ns / 1ps

interface epm_result_if;
    logic                      valid;
    logic                      ready;
    logic [epm_pkg::POS_W-1:0] match_position;

    modport source (output valid, match_position, input ready);
    modport sink (input valid, match_position, output ready);
endinterface

@@ rtl/core/epm_cfg_if.sv @@
// pattern length write channel of the byte pattern matcher
// depends on epm_pkg
`timescale 1ns / 1ps

interface epm_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [epm_pkg::CFG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

@@ rtl/core/epm_cell.sv @@
// one cell of the matcher chain: a text window byte and a pattern ring byte
// depends on epm_pkg
`timescale 1ns / 1ps

module epm_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  epm_pkg::cell_ctl_t         ctl,
    input  logic [epm_pkg::BYTE_W-1:0] win_in,
    input  logic [epm_pkg::BYTE_W-1:0] pat_in,
    output logic [epm_pkg::BYTE_W-1:0] win_out,
    output logic [epm_pkg::BYTE_W-1:0] pat_out,
    output logic                       eq
);

    logic [epm_pkg::BYTE_W-1:0] window_reg;
    logic [epm_pkg::BYTE_W-1:0] window_next;
    logic [epm_pkg::BYTE_W-1:0] pattern_reg;
    logic [epm_pkg::BYTE_W-1:0] pattern_next;

    always_comb
    begin
        window_next = window_reg;
        if (ctl.clear_en)
        begin
            window_next = '0;
        end
        else if (ctl.shift_en)
        begin
            window_next = win_in;
        end
    end

    always_comb
    begin
        pattern_next = pattern_reg;
        if (ctl.load_en)
        begin
            pattern_next = ctl.data;
        end
        else if (ctl.rotate_en)
        begin
            pattern_next = pat_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else
        begin
            window_reg <= window_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pattern_reg <= pattern_next;
    end

    assign win_out = window_reg;
    assign pat_out = pattern_reg;
    assign eq      = (window_reg == pattern_reg);

endmodule

@@ rtl/core/epm_chain.sv @@
// row of matcher cells with load decode, in-use mask and match reduction
// depends on epm_pkg and epm_cell
`timescale 1ns / 1ps

module epm_chain (
    input  logic                       clk,
    input  logic                       rst_n,
    input  epm_pkg::chain_ctl_t        ctl,
    input  logic [epm_pkg::ALEN_W-1:0] active_len,
    output logic                       hit
);

    localparam int MAX = epm_pkg::MAX_PATTERN;

    logic [epm_pkg::BYTE_W-1:0] win [MAX];
    logic [epm_pkg::BYTE_W-1:0] pat [MAX];
    logic [MAX-1:0]             eq;
    logic [MAX-1:0]             in_use;

    for (genvar g = 0; g < MAX; g++)
    begin : g_cell
        epm_pkg::cell_ctl_t         cc;
        logic [epm_pkg::IDX_W:0]    ring_sum;
        logic [epm_pkg::IDX_W:0]    ring_idx;
        logic [epm_pkg::BYTE_W-1:0] win_in;
        logic [epm_pkg::ALEN_W:0]   reach;

        // pattern index held by this ring slot
        assign ring_sum = {1'b0, ctl.offset} + (epm_pkg::IDX_W + 1)'(g);
        assign ring_idx = (ring_sum >= (epm_pkg::IDX_W + 1)'(MAX))
                        ? ring_sum - (epm_pkg::IDX_W + 1)'(MAX) : ring_sum;

        assign cc.load_en   = ctl.load_en
                            && (int'(ring_idx[epm_pkg::IDX_W-1:0]) == int'(ctl.index));
        assign cc.shift_en  = ctl.shift_en;
        assign cc.clear_en  = ctl.clear_en;
        assign cc.rotate_en = ctl.rotate_en;
        assign cc.data      = ctl.data;

        if (g == MAX - 1)
        begin : g_last
            assign win_in = ctl.data;
        end
        else
        begin : g_mid
            assign win_in = win[g + 1];
        end

        // slot lies within the newest active_len bytes
        assign reach     = (epm_pkg::ALEN_W + 1)'(g) + {1'b0, active_len};
        assign in_use[g] = (reach >= (epm_pkg::ALEN_W + 1)'(MAX));

        epm_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (cc),
            .win_in  (win_in),
            .pat_in  (pat[(g + 1) % MAX]),
            .win_out (win[g]),
            .pat_out (pat[g]),
            .eq      (eq[g])
        );
    end

    assign hit = &(eq | ~in_use);

endmodule

@@ rtl/core/exact_byte_pattern_matcher.sv @@
// Exact byte pattern matcher. Pattern bytes are loaded by index and text bytes stream in
// one per beat; each text beat whose newest pattern_length bytes equal the pattern gives
// one result beat with the start offset of that window. The block takes one item per
// clock cycle when it does not stall; after its text beat a result is registered by the
// shift into the cell chain and then by the parallel compare into the output register.
// Input stalls only while the pattern ring rotates, or while a result waits in the output
// register and another compare is pending. After a pattern_length write the pattern ring
// in the cells rotates into place, one slot a cycle, and no item is taken meanwhile.
// Depends on epm_pkg, the channel interfaces, epm_chain and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module exact_byte_pattern_matcher (
    input  logic          clk,
    input  logic          rst_n,
    epm_cfg_if.sink       cfg,
    epm_item_if.sink      item,
    epm_result_if.source  result
);

    localparam int MAX = epm_pkg::MAX_PATTERN;

    logic [epm_pkg::CFG_W-1:0]  len_reg;
    logic [epm_pkg::ALEN_W-1:0] active_len;
    logic [epm_pkg::IDX_W-1:0]  target;
    logic [epm_pkg::IDX_W-1:0]  offset_reg;
    logic [epm_pkg::IDX_W-1:0]  offset_next;
    logic                       busy;

    logic [epm_pkg::POS_W-1:0]  count_reg;
    logic [epm_pkg::POS_W-1:0]  count_next;
    logic [epm_pkg::POS_W-1:0]  count_inc;

    logic                       pend_valid_reg;
    logic                       pend_valid_next;
    logic                       pend_ok_reg;
    logic [epm_pkg::POS_W-1:0]  pend_pos_reg;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [epm_pkg::POS_W-1:0]  out_pos_reg;

    logic                       accept;
    logic                       do_load;
    logic                       do_text;
    logic                       do_start;
    logic                       out_free;
    logic                       pend_adv;
    logic                       hit;
    epm_pkg::action_t           act;
    epm_pkg::chain_ctl_t        ctl;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= epm_pkg::CFG_W'(1);
        end
        else if (cfg.valid)
        begin
            len_reg <= cfg.data;
        end
    end

    always_comb
    begin
        if (len_reg == '0)
        begin
            active_len = epm_pkg::ALEN_W'(1);
        end
        else if (int'(len_reg) > MAX)
        begin
            active_len = epm_pkg::ALEN_W'(MAX);
        end
        else
        begin
            active_len = epm_pkg::ALEN_W'(len_reg);
        end
    end

    // ring offset follows active length modulo the ring size
    assign target = (active_len == epm_pkg::ALEN_W'(MAX))
                  ? '0 : active_len[epm_pkg::IDX_W-1:0];
    assign busy   = (offset_reg != target);

    always_comb
    begin
        offset_next = offset_reg;
        if (busy)
        begin
            offset_next = (offset_reg == epm_pkg::IDX_W'(MAX - 1))
                        ? '0 : offset_reg + epm_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= epm_pkg::IDX_W'(1);
        end
        else
        begin
            offset_reg <= offset_next;
        end
    end

    // input decode
    assign out_free   = !out_valid_reg || result.ready;
    assign pend_adv   = pend_valid_reg && out_free;
    assign item.ready = !busy && (!pend_valid_reg || out_free);
    assign accept     = item.valid && item.ready;
    assign act        = epm_pkg::action_t'(item.action);

    always_comb
    begin
        do_load  = 1'b0;
        do_text  = 1'b0;
        do_start = 1'b0;
        case (act)
            epm_pkg::ACT_LOAD:  do_load  = accept;
            epm_pkg::ACT_TEXT:  do_text  = accept;
            epm_pkg::ACT_START: do_start = accept;
            default:
            begin
                do_load  = 1'b0;
                do_text  = 1'b0;
                do_start = 1'b0;
            end
        endcase
    end

    assign ctl.load_en   = do_load;
    assign ctl.shift_en  = do_text;
    assign ctl.clear_en  = do_start;
    assign ctl.rotate_en = busy;
    assign ctl.offset    = offset_reg;
    assign ctl.index     = item.pattern_index;
    assign ctl.data      = item.byte_value;

    epm_chain u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .active_len (active_len),
        .hit        (hit)
    );

    // text position, saturating
    assign count_inc = (count_reg == epm_pkg::POS_MAX)
                     ? count_reg : count_reg + epm_pkg::POS_W'(1);

    always_comb
    begin
        count_next = count_reg;
        if (do_start)
        begin
            count_next = '0;
        end
        else if (do_text)
        begin
            count_next = count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // compare stage
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (do_text)
        begin
            pend_valid_next = 1'b1;
        end
        else if (pend_adv)
        begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_text)
        begin
            pend_ok_reg  <= (count_inc >= epm_pkg::POS_W'(active_len));
            pend_pos_reg <= count_inc - epm_pkg::POS_W'(active_len);
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = pend_valid_reg && pend_ok_reg && hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_pos_reg <= pend_pos_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.match_position = out_pos_reg;

    `ASSERT_IMPL(a_stall_blocks_input, clk, rst_n, pend_valid_reg && !out_free, !item.ready, "input taken while compare stage is stalled")
    `ASSERT_IMPL(a_out_from_compare, clk, rst_n, $rose(out_valid_reg), $past(pend_valid_reg), "result beat without a pending compare")
    `ASSERT_NEXT(a_count_saturates, clk, rst_n, (count_reg == epm_pkg::POS_MAX) && !do_start, count_reg == epm_pkg::POS_MAX, "text position left saturation")
    `ASSERT_IMPL(a_len_in_range, clk, rst_n, 1'b1, (active_len != '0) && (int'(active_len) <= MAX), "active length out of range")

endmodule
